@@ hw/rtl/lars_pkg.sv @@
package lars_pkg;

	localparam int AW_W = 7;
	typedef logic [AW_W-1:0] aw_t;
	localparam aw_t AW_RESET = aw_t'(64);

	// neighbor count of one cell: 0..8
	localparam int CNT_W = 4;
	typedef logic [CNT_W-1:0] cnt_t;
	localparam cnt_t BORN_CNT    = cnt_t'(3);
	localparam cnt_t SURVIVE_CNT = cnt_t'(2);

	// result queue occupancy and per-item push count: 0..2
	typedef logic [1:0] qcnt_t;
	localparam qcnt_t QUEUE_DEPTH = qcnt_t'(2);

endpackage

@@ hw/rtl/lars_life_row.sv @@
module lars_life_row #(
	parameter int ROW_CELLS = 64
) (
	input  logic [ROW_CELLS-1:0] above,
	input  logic [ROW_CELLS-1:0] here,
	input  logic [ROW_CELLS-1:0] below,
	input  lars_pkg::aw_t        active_width,
	output logic [ROW_CELLS-1:0] next
);
	import lars_pkg::*;

	logic [ROW_CELLS-1:0] mask;
	logic [ROW_CELLS-1:0] a_m;
	logic [ROW_CELLS-1:0] h_m;
	logic [ROW_CELLS-1:0] b_m;

	assign a_m = above & mask;
	assign h_m = here & mask;
	assign b_m = below & mask;

	for (genvar i = 0; i < ROW_CELLS; i++) begin : g_cell
		logic [2:0] lft;
		logic [2:0] rgt;
		cnt_t       cnt;
		logic       alive;

		assign mask[i] = active_width > aw_t'(i);

		if (i > 0) begin : g_lft
			assign lft = {a_m[i-1], h_m[i-1], b_m[i-1]};
		end else begin : g_lft_edge
			assign lft = '0;
		end

		if (i < ROW_CELLS - 1) begin : g_rgt
			assign rgt = {a_m[i+1], h_m[i+1], b_m[i+1]};
		end else begin : g_rgt_edge
			assign rgt = '0;
		end

		assign cnt = cnt_t'(lft[0]) + cnt_t'(lft[1]) + cnt_t'(lft[2])
			+ cnt_t'(rgt[0]) + cnt_t'(rgt[1]) + cnt_t'(rgt[2])
			+ cnt_t'(a_m[i]) + cnt_t'(b_m[i]);
		assign alive = h_m[i];
		assign next[i] = mask[i] & ((cnt == BORN_CNT) | (alive & (cnt == SURVIVE_CNT)));
	end

endmodule

@@ hw/rtl/lars_out_queue.sv @@
module lars_out_queue #(
	parameter int W = 65
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lars_pkg::qcnt_t push_cnt,
	input  logic [W-1:0]    push0,
	input  logic [W-1:0]    push1,
	input  logic            pop_ready,
	output logic            head_valid,
	output logic [W-1:0]    head,
	output lars_pkg::qcnt_t cnt_after_pop
);
	import lars_pkg::*;

	qcnt_t      cnt_q;
	logic [W-1:0] slot0_q;
	logic [W-1:0] slot1_q;
	logic         pop;
	logic [W-1:0] keep0;
	logic [W-1:0] slot0_d;
	logic [W-1:0] slot1_d;

	assign head_valid    = cnt_q != '0;
	assign head          = slot0_q;
	assign pop           = head_valid & pop_ready;
	assign cnt_after_pop = cnt_q - qcnt_t'(pop);
	assign keep0         = pop ? slot1_q : slot0_q;

	always_comb begin
		case (cnt_after_pop)
			2'd0: begin
				slot0_d = push0;
				slot1_d = push1;
			end
			2'd1: begin
				slot0_d = keep0;
				slot1_d = push0;
			end
			default: begin
				slot0_d = slot0_q;
				slot1_d = slot1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_after_pop + push_cnt;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_DEPTH)
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != '0) |->
			({1'b0, cnt_after_pop} + {1'b0, push_cnt} <= {1'b0, QUEUE_DEPTH}))
		else $error("push without room");

endmodule

@@ hw/rtl/life_automaton_row_stepper.sv @@
// Life B3/S23 row stepper on a bounded grid, all cells outside counted dead.
// in channel (in_valid/in_ready): one row per item, top row first;
// last_row marks the bottom row and closes the grid.
// out channel (out_valid/out_ready): next-generation rows in order; last_out
// marks the bottom one. A first row that is not also the last gives no item,
// each later row gives the row above it, and the last row also gives itself.
// cfg channel (cfg_valid/cfg_ready/active_width): columns in use; ready only
// while no item is in flight. Values above ROW_CELLS act as ROW_CELLS.
// Flow: an input item is registered, evaluated from that register, and its
// results land in a two-entry output queue whose occupancy drives out_valid.
// Throughput: one row per cycle while the output queue has room; the bottom
// row of a grid of more than one row yields two items.
// Reset clears the held rows, the queue and sets active_width to 64.
// A stalled receiver fills the queue; in_ready then drops once the item
// in the input register cannot place its results.
module life_automaton_row_stepper #(
	parameter int ROW_CELLS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  lars_pkg::aw_t        active_width,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ROW_CELLS-1:0] row_cells,
	input  logic                 last_row,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROW_CELLS-1:0] next_row,
	output logic                 last_out
);
	import lars_pkg::*;

	aw_t                  width_q;
	logic                 valid_s1;
	logic [ROW_CELLS-1:0] row_s1;
	logic                 last_s1;
	logic [ROW_CELLS-1:0] upper_q;
	logic [ROW_CELLS-1:0] middle_q;
	logic                 pending_q;

	logic [ROW_CELLS-1:0] in_mask;
	logic [ROW_CELLS-1:0] res_mid;
	logic [ROW_CELLS-1:0] res_last;
	logic [ROW_CELLS-1:0] last_above;
	qcnt_t                res_cnt;
	qcnt_t                push_cnt;
	qcnt_t                q_after_pop;
	logic                 advance;
	logic [ROW_CELLS:0]   push0;
	logic [ROW_CELLS:0]   push1;
	logic [ROW_CELLS:0]   head;

	for (genvar i = 0; i < ROW_CELLS; i++) begin : g_mask
		assign in_mask[i] = width_q > aw_t'(i);
	end

	assign res_cnt  = qcnt_t'(pending_q) + qcnt_t'(last_s1);
	assign advance  = valid_s1
		& ({1'b0, q_after_pop} + {1'b0, res_cnt} <= {1'b0, QUEUE_DEPTH});
	assign push_cnt = advance ? res_cnt : '0;
	assign in_ready = ~valid_s1 | advance;
	assign cfg_ready = ~valid_s1 & ~out_valid & ~in_valid;

	assign last_above = pending_q ? middle_q : '0;

	lars_life_row #(.ROW_CELLS(ROW_CELLS)) u_row_mid (
		.above       (upper_q),
		.here        (middle_q),
		.below       (row_s1),
		.active_width(width_q),
		.next        (res_mid)
	);

	lars_life_row #(.ROW_CELLS(ROW_CELLS)) u_row_last (
		.above       (last_above),
		.here        (row_s1),
		.below       ('0),
		.active_width(width_q),
		.next        (res_last)
	);

	assign push0 = pending_q ? {1'b0, res_mid} : {1'b1, res_last};
	assign push1 = {1'b1, res_last};

	lars_out_queue #(.W(ROW_CELLS + 1)) u_out_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_cnt     (push_cnt),
		.push0        (push0),
		.push1        (push1),
		.pop_ready    (out_ready),
		.head_valid   (out_valid),
		.head         (head),
		.cnt_after_pop(q_after_pop)
	);

	assign next_row = head[ROW_CELLS-1:0];
	assign last_out = head[ROW_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= AW_RESET;
			valid_s1  <= 1'b0;
			upper_q   <= '0;
			middle_q  <= '0;
			pending_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				width_q <= active_width;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (last_s1) begin
					upper_q   <= '0;
					middle_q  <= '0;
					pending_q <= 1'b0;
				end else begin
					upper_q   <= middle_q;
					middle_q  <= row_s1;
					pending_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			row_s1  <= row_cells & in_mask;
			last_s1 <= last_row;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (upper_q == '0) && (middle_q == '0))
		else $error("held rows not cleared between grids");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> !pending_q)
		else $error("grid not closed after bottom row");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && pending_q && last_s1 |=> out_valid && !last_out)
		else $error("bottom row pair out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !pending_q && !last_s1 |=> $stable(out_valid) || $fell(out_valid))
		else $error("first row of a grid produced an item");

endmodule

@@ test/life_automaton_row_stepper_test.sv @@
`timescale 1ns / 100ps

module life_automaton_row_stepper_test;
	import lars_pkg::*;

	localparam int ROW_CELLS    = 64;
	localparam int IDLE_PCT     = 31;
	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PLAN_LEN     = 33;

	typedef logic [ROW_CELLS-1:0] row_t;

	typedef enum logic {STEP_ROW, STEP_WIDTH} step_e;

	typedef struct packed {
		step_e kind;
		row_t  cells;
		logic  last;
		aw_t   width;
		logic  fixed;
		row_t  want;
	} step_t;

	typedef struct packed {
		row_t row;
		logic last;
	} due_t;

	logic clk          = 1'b0;
	logic arst_n       = 1'b0;
	logic cfg_valid    = 1'b0;
	logic cfg_ready;
	aw_t  active_width = AW_RESET;
	logic in_valid     = 1'b0;
	logic in_ready;
	row_t row_cells    = '0;
	logic last_row     = 1'b0;
	logic out_valid;
	logic out_ready    = 1'b0;
	row_t next_row;
	logic last_out;

	// predictor state
	aw_t  pred_width = AW_RESET;
	row_t held_above = '0;
	row_t held_row   = '0;
	logic row_held   = 1'b0;

	due_t next_rows_due[$];

	int   errors    = 0;
	int   cycles    = 0;
	int   idle_pct  = IDLE_PCT;
	bit   hold_req  = 1'b0;
	bit   fixed_due = 1'b0;
	row_t fixed_row = '0;

	step_t plan [PLAN_LEN] = '{
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(64),  1'b0, 64'h0},
		'{STEP_ROW,   64'h0,                   1'b1, aw_t'(0),   1'b1, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, aw_t'(0),   1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
		'{STEP_ROW,   64'h8000_0000_0000_0001, 1'b1, aw_t'(0),   1'b1, 64'h0},
		'{STEP_ROW,   64'h0000_0000_0038_0000, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'h0000_0000_0038_0000, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'h0000_0000_0038_0000, 1'b1, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hC000_0000_0000_0003, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hC000_0000_0000_0003, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hC000_0000_0000_0003, 1'b1, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'h2,                   1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'h4,                   1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'h7,                   1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'h0,                   1'b1, aw_t'(0),   1'b0, 64'h0},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, aw_t'(0),   1'b1, 64'h0},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(127), 1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, aw_t'(0),   1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(3),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, aw_t'(0),   1'b1, 64'h2},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(1),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, aw_t'(0),   1'b1, 64'h0},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(64),  1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(10),  1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_WIDTH, 64'h0,                   1'b0, aw_t'(64),  1'b0, 64'h0},
		'{STEP_ROW,   64'hA5A5_5A5A_F00F_0FF0, 1'b1, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, aw_t'(0),   1'b0, 64'h0},
		'{STEP_ROW,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, aw_t'(0),   1'b0, 64'h0}
	};

	life_automaton_row_stepper #(
		.ROW_CELLS(ROW_CELLS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.active_width(active_width),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row_cells   (row_cells),
		.last_row    (last_row),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.next_row    (next_row),
		.last_out    (last_out)
	);

	always #5 clk = ~clk;

	function automatic row_t column_mask(aw_t w);
		if (w >= aw_t'(ROW_CELLS))
			return '1;
		return (row_t'(1) << w) - row_t'(1);
	endfunction

	function automatic row_t life_next_row(row_t above, row_t here, row_t below, row_t m);
		row_t a;
		row_t h;
		row_t b;
		row_t res;
		int   cnt;
		a   = above & m;
		h   = here & m;
		b   = below & m;
		res = '0;
		for (int i = 0; i < ROW_CELLS; i++) begin
			cnt = a[i] + b[i];
			if (i > 0)
				cnt += a[i-1] + h[i-1] + b[i-1];
			if (i < ROW_CELLS - 1)
				cnt += a[i+1] + h[i+1] + b[i+1];
			if (cnt == int'(BORN_CNT) || (h[i] && cnt == int'(SURVIVE_CNT)))
				res[i] = 1'b1;
		end
		return res & m;
	endfunction

	function automatic row_t random_row();
		case ($urandom_range(4))
			0: return {$urandom, $urandom};
			1: return {$urandom, $urandom} & {$urandom, $urandom};
			2: return {$urandom, $urandom} | {$urandom, $urandom};
			3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	function automatic aw_t pick_width();
		case ($urandom_range(11))
			0: return aw_t'(0);
			1: return aw_t'(1);
			2: return aw_t'(2);
			3: return aw_t'(63);
			4: return aw_t'($urandom_range(65, 126));
			5: return aw_t'(127);
			6, 7, 8: return aw_t'(64);
			default: return aw_t'($urandom_range(3, 64));
		endcase
	endfunction

	// all tasks start and end at a falling edge
	task automatic send_row(input row_t cells, input logic last, input logic fixed,
			input row_t fixed_val);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		row_cells <= cells;
		last_row  <= last;
		fixed_due = fixed;
		fixed_row = fixed_val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_width(input aw_t w);
		in_valid <= 1'b0;
		while (next_rows_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid    <= 1'b1;
		active_width <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver
	initial begin : sink
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// predictor and scoreboard
	always @(posedge clk) begin : check
		row_t m;
		row_t row;
		due_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				pred_width = active_width;
			if (in_valid && in_ready) begin
				m   = column_mask(pred_width);
				row = row_cells & m;
				if (row_held) begin
					next_rows_due.push_back('{life_next_row(held_above, held_row, row, m),
						1'b0});
					held_above = held_row;
				end else begin
					held_above = '0;
				end
				held_row = row;
				row_held = 1'b1;
				if (last_row) begin
					if (fixed_due)
						next_rows_due.push_back('{fixed_row, 1'b1});
					else
						next_rows_due.push_back('{life_next_row(held_above, held_row, '0, m),
							1'b1});
					held_above = '0;
					held_row   = '0;
					row_held   = 1'b0;
				end
			end
			if (out_valid && out_ready) begin
				if (next_rows_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected item next_row %h last_out %b", $time,
						next_row, last_out);
				end else begin
					want = next_rows_due.pop_front();
					if (next_row !== want.row) begin
						errors++;
						$display("%0t: next_row expected %h actual %h", $time, want.row,
							next_row);
					end
					if (last_out !== want.last) begin
						errors++;
						$display("%0t: last_out expected %b actual %b", $time, want.last,
							last_out);
					end
				end
			end
		end
	end

	// sender
	initial begin : drive
		int sent;
		int grid_rows;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == STEP_WIDTH)
				set_width(plan[k].width);
			else
				send_row(plan[k].cells, plan[k].last, plan[k].fixed, plan[k].want);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(3) == 0)
				set_width(pick_width());
			grid_rows = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 8);
			for (int r = 0; r < grid_rows; r++) begin
				if (r > 0 && $urandom_range(25) == 0)
					set_width(pick_width());
				if ((sent >= 200 && sent < 320) || (sent >= 400 && sent < 440))
					idle_pct = 0;
				else
					idle_pct = IDLE_PCT;
				if (sent == 400)
					hold_req = 1'b1;
				send_row(random_row(), r == grid_rows - 1, 1'b0, '0);
				sent++;
			end
		end

		in_valid <= 1'b0;
		while (next_rows_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (next_rows_due.size() != 0)
			errors++;
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/lars_pkg.sv
hw/rtl/lars_life_row.sv
hw/rtl/lars_out_queue.sv
hw/rtl/life_automaton_row_stepper.sv
test/life_automaton_row_stepper_test.sv
